>>> rtl/ihc_pkg.sv
// ----------------------------------------------------------------------------
// ihc_pkg: shared types and constants for the IPv4 L4 header classifier
// Frame offsets, protocol numbers, record codes and the service lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package ihc_pkg;

  localparam int MAX_FRAME_BYTES = 65535;

  localparam int IDX_W      = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // register word index
  localparam logic REG_CAPTURE_ENABLE = 1'b0;

  // byte offsets from frame start (L4_* offsets from the L4 header start)
  localparam logic [IDX_W-1:0] ETH_HDR_LEN  = 16'd14;
  localparam logic [IDX_W-1:0] OFF_ETYPE_HI = 16'd12;
  localparam logic [IDX_W-1:0] OFF_ETYPE_LO = 16'd13;
  localparam logic [IDX_W-1:0] OFF_IHL      = 16'd14;
  localparam logic [IDX_W-1:0] OFF_PROTO    = 16'd23;
  localparam logic [IDX_W-1:0] OFF_SRC0     = 16'd26;
  localparam logic [IDX_W-1:0] OFF_SRC1     = 16'd27;
  localparam logic [IDX_W-1:0] OFF_SRC2     = 16'd28;
  localparam logic [IDX_W-1:0] OFF_SRC3     = 16'd29;
  localparam logic [IDX_W-1:0] OFF_DST0     = 16'd30;
  localparam logic [IDX_W-1:0] OFF_DST1     = 16'd31;
  localparam logic [IDX_W-1:0] OFF_DST2     = 16'd32;
  localparam logic [IDX_W-1:0] OFF_DST3     = 16'd33;
  localparam logic [IDX_W-1:0] L4_SPORT_HI  = 16'd0;
  localparam logic [IDX_W-1:0] L4_SPORT_LO  = 16'd1;
  localparam logic [IDX_W-1:0] L4_DPORT_HI  = 16'd2;
  localparam logic [IDX_W-1:0] L4_DPORT_LO  = 16'd3;
  localparam logic [IDX_W-1:0] L4_TCP_DOFF  = 16'd12;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;

  localparam logic [7:0] PROTO_ICMP = 8'd1;
  localparam logic [7:0] PROTO_TCP  = 8'd6;
  localparam logic [7:0] PROTO_UDP  = 8'd17;

  localparam logic [17:0] TCP_MIN_LEN = 18'd20;
  localparam logic [17:0] UDP_LEN     = 18'd8;

  localparam logic [1:0] CLS_OTHER = 2'd0;
  localparam logic [1:0] CLS_TCP   = 2'd1;
  localparam logic [1:0] CLS_UDP   = 2'd2;
  localparam logic [1:0] CLS_ICMP  = 2'd3;

  localparam logic [3:0] SVC_NONE     = 4'd0;
  localparam logic [3:0] SVC_HTTP     = 4'd1;
  localparam logic [3:0] SVC_DNS      = 4'd2;
  localparam logic [3:0] SVC_SSH      = 4'd3;
  localparam logic [3:0] SVC_SMTP     = 4'd4;
  localparam logic [3:0] SVC_FTP      = 4'd5;
  localparam logic [3:0] SVC_MYSQL    = 4'd6;
  localparam logic [3:0] SVC_HTTPS    = 4'd7;
  localparam logic [3:0] SVC_HTTP_ALT = 4'd8;
  localparam logic [3:0] SVC_TELNET   = 4'd9;
  localparam logic [3:0] SVC_PING     = 4'd10;

  localparam logic [15:0] PORT_HTTP     = 16'd80;
  localparam logic [15:0] PORT_DNS      = 16'd53;
  localparam logic [15:0] PORT_SSH      = 16'd22;
  localparam logic [15:0] PORT_SMTP     = 16'd25;
  localparam logic [15:0] PORT_FTP      = 16'd21;
  localparam logic [15:0] PORT_MYSQL    = 16'd3306;
  localparam logic [15:0] PORT_HTTPS    = 16'd443;
  localparam logic [15:0] PORT_HTTP_ALT = 16'd8080;
  localparam logic [15:0] PORT_TELNET   = 16'd23;

  // header fields of one finished IPv4 frame
  typedef struct packed {
    logic [3:0]  header_words;
    logic [7:0]  ip_protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  tcp_words;
    logic [15:0] wire_len;
  } hdr_t;

  typedef struct packed {
    logic [1:0]  protocol_class;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [3:0]  service_code;
    logic        payload_present;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;
    logic [15:0] frame_size;
  } rec_t;

  function automatic logic [3:0] service_of(input logic [15:0] port);
    logic [3:0] svc;
    case (port)
      PORT_HTTP:     svc = SVC_HTTP;
      PORT_DNS:      svc = SVC_DNS;
      PORT_SSH:      svc = SVC_SSH;
      PORT_SMTP:     svc = SVC_SMTP;
      PORT_FTP:      svc = SVC_FTP;
      PORT_MYSQL:    svc = SVC_MYSQL;
      PORT_HTTPS:    svc = SVC_HTTPS;
      PORT_HTTP_ALT: svc = SVC_HTTP_ALT;
      PORT_TELNET:   svc = SVC_TELNET;
      default:       svc = SVC_NONE;
    endcase
    return svc;
  endfunction

endpackage

`default_nettype wire

>>> rtl/ipv4_l4_header_classifier_core.sv
// ----------------------------------------------------------------------------
// ipv4_l4_header_classifier_core: Ethernet/IPv4/TCP-UDP header classifier
// Takes a frame one byte per request and emits one record per IPv4 frame
// while capture is enabled.
// ----------------------------------------------------------------------------
//   Channel  Direction  Request content
//   in_      sink       one frame byte with start/end marks and wire length
//   out_     source     one header record per IPv4 frame
//   cfg_     APB slave  capture_enable at byte address 0
//
// One byte is taken every cycle while in_ready is high. A record passes from
// the last byte of its frame through the capture snapshot register, then the
// record register, to out_. rst_n clears frame state and capture_enable;
// no clearing pass. out_ready low first fills the record register, then the
// snapshot register; in_ready drops only when both hold a record.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv4_l4_header_classifier_core #(
  parameter int MAX_FRAME_BYTES = ihc_pkg::MAX_FRAME_BYTES
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [7:0]                       in_data_byte,
  input  wire logic                             in_frame_start,
  input  wire logic                             in_frame_end,
  input  wire logic [15:0]                      in_wire_length,

  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [1:0]                            out_protocol_class,
  output logic [31:0]                           out_source_address,
  output logic [31:0]                           out_dest_address,
  output logic [15:0]                           out_source_port,
  output logic [15:0]                           out_dest_port,
  output logic [3:0]                            out_service_code,
  output logic                                  out_payload_present,
  output logic [15:0]                           out_payload_offset,
  output logic [15:0]                           out_payload_length,
  output logic [15:0]                           out_frame_size,

  input  wire logic                             cfg_psel,
  input  wire logic                             cfg_penable,
  input  wire logic                             cfg_pwrite,
  input  wire logic [ihc_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [ihc_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [ihc_pkg::CFG_DATA_W-1:0]        cfg_prdata,
  output logic                                  cfg_pready
);

  logic           capture_enable_r, capture_enable_nxt;
  logic           cfg_hit;
  ihc_pkg::hdr_t  hdr;
  logic           hdr_valid;
  logic           hdr_ready;
  ihc_pkg::rec_t  rec;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[ihc_pkg::CFG_ADDR_W-1] == ihc_pkg::REG_CAPTURE_ENABLE);

  always_comb begin
    capture_enable_nxt = capture_enable_r;
    if (cfg_psel && cfg_penable && cfg_pwrite && cfg_hit) begin
      capture_enable_nxt = cfg_pwdata[0];
    end
    cfg_prdata = cfg_hit ? {{(ihc_pkg::CFG_DATA_W-1){1'b0}}, capture_enable_r} : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capture_enable_r <= 1'b0;
    end else begin
      capture_enable_r <= capture_enable_nxt;
    end
  end

  ihc_capture #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_capture (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (in_data_byte),
    .frame_start    (in_frame_start),
    .frame_end      (in_frame_end),
    .wire_length    (in_wire_length),
    .capture_enable (capture_enable_r),
    .hdr            (hdr),
    .hdr_valid      (hdr_valid),
    .hdr_ready      (hdr_ready)
  );

  ihc_classify u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .hdr       (hdr),
    .hdr_valid (hdr_valid),
    .hdr_ready (hdr_ready),
    .rec       (rec),
    .rec_valid (out_valid),
    .rec_ready (out_ready)
  );

  assign out_protocol_class  = rec.protocol_class;
  assign out_source_address  = rec.source_address;
  assign out_dest_address    = rec.dest_address;
  assign out_source_port     = rec.source_port;
  assign out_dest_port       = rec.dest_port;
  assign out_service_code    = rec.service_code;
  assign out_payload_present = rec.payload_present;
  assign out_payload_offset  = rec.payload_offset;
  assign out_payload_length  = rec.payload_length;
  assign out_frame_size      = rec.frame_size;

endmodule

`default_nettype wire

>>> rtl/ihc_capture.sv
// ----------------------------------------------------------------------------
// ihc_capture: per-byte header capture
// Tracks the byte index, captures header fields of the running frame and
// hands a snapshot of them to the classifier at the last byte of an IPv4 frame
// while capture is enabled.
`default_nettype none

module ihc_capture #(
  parameter int MAX_FRAME_BYTES = ihc_pkg::MAX_FRAME_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        data_byte,
  input  wire logic              frame_start,
  input  wire logic              frame_end,
  input  wire logic [15:0]       wire_length,
  input  wire logic              capture_enable,
  output ihc_pkg::hdr_t          hdr,
  output logic                   hdr_valid,
  input  wire logic              hdr_ready
);

  localparam logic [ihc_pkg::IDX_W-1:0] MaxIdx = ihc_pkg::IDX_W'(MAX_FRAME_BYTES);

  logic [ihc_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]               etype_r, etype_nxt;
  logic [3:0]                hw_r, hw_nxt;
  logic [7:0]                proto_r, proto_nxt;
  logic [31:0]               src_r, src_nxt;
  logic [31:0]               dst_r, dst_nxt;
  logic [15:0]               sport_r, sport_nxt;
  logic [15:0]               dport_r, dport_nxt;
  logic [3:0]                tcpw_r, tcpw_nxt;
  logic [15:0]               wlen_r, wlen_nxt;
  logic                      hdr_valid_r, hdr_valid_nxt;
  ihc_pkg::hdr_t             hdr_r, hdr_nxt;

  logic                      accept;
  logic                      take;
  logic                      emit;
  logic [ihc_pkg::IDX_W-1:0] base_idx;
  logic [ihc_pkg::IDX_W-1:0] l4;

  assign in_ready  = !hdr_valid_r || hdr_ready;
  assign accept    = in_valid && in_ready;
  assign hdr       = hdr_r;
  assign hdr_valid = hdr_valid_r;

  always_comb begin
    // frame start restarts from cleared state with the sampled wire length
    base_idx  = frame_start ? '0 : idx_r;
    etype_nxt = frame_start ? '0 : etype_r;
    hw_nxt    = frame_start ? '0 : hw_r;
    proto_nxt = frame_start ? '0 : proto_r;
    src_nxt   = frame_start ? '0 : src_r;
    dst_nxt   = frame_start ? '0 : dst_r;
    sport_nxt = frame_start ? '0 : sport_r;
    dport_nxt = frame_start ? '0 : dport_r;
    tcpw_nxt  = frame_start ? '0 : tcpw_r;
    wlen_nxt  = frame_start ? wire_length : wlen_r;

    take = base_idx < MaxIdx;

    if (take) begin
      if (base_idx == ihc_pkg::OFF_ETYPE_HI) etype_nxt[15:8] = data_byte;
      if (base_idx == ihc_pkg::OFF_ETYPE_LO) etype_nxt[7:0]  = data_byte;
      if (base_idx == ihc_pkg::OFF_IHL)      hw_nxt          = data_byte[3:0];
      if (base_idx == ihc_pkg::OFF_PROTO)    proto_nxt       = data_byte;
      if (base_idx == ihc_pkg::OFF_SRC0)     src_nxt[31:24]  = data_byte;
      if (base_idx == ihc_pkg::OFF_SRC1)     src_nxt[23:16]  = data_byte;
      if (base_idx == ihc_pkg::OFF_SRC2)     src_nxt[15:8]   = data_byte;
      if (base_idx == ihc_pkg::OFF_SRC3)     src_nxt[7:0]    = data_byte;
      if (base_idx == ihc_pkg::OFF_DST0)     dst_nxt[31:24]  = data_byte;
      if (base_idx == ihc_pkg::OFF_DST1)     dst_nxt[23:16]  = data_byte;
      if (base_idx == ihc_pkg::OFF_DST2)     dst_nxt[15:8]   = data_byte;
      if (base_idx == ihc_pkg::OFF_DST3)     dst_nxt[7:0]    = data_byte;
    end

    // L4 offset sees the header length written by this same byte
    l4 = ihc_pkg::ETH_HDR_LEN + {10'd0, hw_nxt, 2'b00};

    if (take) begin
      if (base_idx == l4 + ihc_pkg::L4_SPORT_HI) sport_nxt[15:8] = data_byte;
      if (base_idx == l4 + ihc_pkg::L4_SPORT_LO) sport_nxt[7:0]  = data_byte;
      if (base_idx == l4 + ihc_pkg::L4_DPORT_HI) dport_nxt[15:8] = data_byte;
      if (base_idx == l4 + ihc_pkg::L4_DPORT_LO) dport_nxt[7:0]  = data_byte;
      if (base_idx == l4 + ihc_pkg::L4_TCP_DOFF) tcpw_nxt        = data_byte[7:4];
    end

    idx_nxt = take ? base_idx + 1'b1 : base_idx;

    emit = frame_end && capture_enable && (etype_nxt == ihc_pkg::ETYPE_IPV4);

    hdr_nxt.header_words = hw_nxt;
    hdr_nxt.ip_protocol  = proto_nxt;
    hdr_nxt.src_addr     = src_nxt;
    hdr_nxt.dst_addr     = dst_nxt;
    hdr_nxt.src_port     = sport_nxt;
    hdr_nxt.dst_port     = dport_nxt;
    hdr_nxt.tcp_words    = tcpw_nxt;
    hdr_nxt.wire_len     = wlen_nxt;

    if (frame_end) begin
      idx_nxt   = '0;
      etype_nxt = '0;
      hw_nxt    = '0;
      proto_nxt = '0;
      src_nxt   = '0;
      dst_nxt   = '0;
      sport_nxt = '0;
      dport_nxt = '0;
      tcpw_nxt  = '0;
      wlen_nxt  = '0;
    end

    if (accept && emit) begin
      hdr_valid_nxt = 1'b1;
    end else if (hdr_ready) begin
      hdr_valid_nxt = 1'b0;
    end else begin
      hdr_valid_nxt = hdr_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      etype_r     <= '0;
      hw_r        <= '0;
      proto_r     <= '0;
      src_r       <= '0;
      dst_r       <= '0;
      sport_r     <= '0;
      dport_r     <= '0;
      tcpw_r      <= '0;
      wlen_r      <= '0;
      hdr_valid_r <= 1'b0;
    end else begin
      hdr_valid_r <= hdr_valid_nxt;
      if (accept) begin
        idx_r   <= idx_nxt;
        etype_r <= etype_nxt;
        hw_r    <= hw_nxt;
        proto_r <= proto_nxt;
        src_r   <= src_nxt;
        dst_r   <= dst_nxt;
        sport_r <= sport_nxt;
        dport_r <= dport_nxt;
        tcpw_r  <= tcpw_nxt;
        wlen_r  <= wlen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      hdr_r <= hdr_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ihc_classify.sv
// ----------------------------------------------------------------------------
// ihc_classify: record builder
// Classifies the protocol, qualifies ports, looks up the service and works
// out payload offset and length; holds the record in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_classify (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  ihc_pkg::hdr_t      hdr,
  input  wire logic          hdr_valid,
  output logic               hdr_ready,
  output ihc_pkg::rec_t      rec,
  output logic               rec_valid,
  input  wire logic          rec_ready
);

  logic                 rec_valid_r, rec_valid_nxt;
  ihc_pkg::rec_t        rec_r, rec_nxt;

  logic [6:0]           l4;
  logic [5:0]           tl;
  logic signed [17:0]   plen;
  logic signed [17:0]   tl_s;
  logic signed [17:0]   pl_tcp;
  logic signed [17:0]   pl_udp;

  assign hdr_ready = !rec_valid_r || rec_ready;
  assign rec       = rec_r;
  assign rec_valid = rec_valid_r;

  always_comb begin
    l4     = 7'(ihc_pkg::ETH_HDR_LEN) + {1'b0, hdr.header_words, 2'b00};
    tl     = {hdr.tcp_words, 2'b00};
    // payload length after the IP header, may go negative
    plen   = $signed({2'b00, hdr.wire_len}) - $signed({11'd0, l4});
    tl_s   = $signed({12'd0, tl});
    pl_tcp = plen - tl_s;
    pl_udp = plen - $signed(ihc_pkg::UDP_LEN);

    rec_nxt.protocol_class  = ihc_pkg::CLS_OTHER;
    rec_nxt.source_address  = hdr.src_addr;
    rec_nxt.dest_address    = hdr.dst_addr;
    rec_nxt.source_port     = '0;
    rec_nxt.dest_port       = '0;
    rec_nxt.service_code    = ihc_pkg::SVC_NONE;
    rec_nxt.payload_present = 1'b0;
    rec_nxt.payload_offset  = '0;
    rec_nxt.payload_length  = '0;
    rec_nxt.frame_size      = hdr.wire_len;

    case (hdr.ip_protocol)
      ihc_pkg::PROTO_TCP: begin
        rec_nxt.protocol_class = ihc_pkg::CLS_TCP;
        if (plen >= $signed(ihc_pkg::TCP_MIN_LEN)) begin
          rec_nxt.source_port  = hdr.src_port;
          rec_nxt.dest_port    = hdr.dst_port;
          rec_nxt.service_code = ihc_pkg::service_of(hdr.dst_port);
          if (plen >= tl_s) begin
            rec_nxt.payload_present = 1'b1;
            rec_nxt.payload_offset  = {9'd0, l4} + {10'd0, tl};
            rec_nxt.payload_length  = pl_tcp[15:0];
          end
        end
      end
      ihc_pkg::PROTO_UDP: begin
        rec_nxt.protocol_class = ihc_pkg::CLS_UDP;
        if (plen >= $signed(ihc_pkg::UDP_LEN)) begin
          rec_nxt.source_port     = hdr.src_port;
          rec_nxt.dest_port       = hdr.dst_port;
          rec_nxt.service_code    = ihc_pkg::service_of(hdr.dst_port);
          rec_nxt.payload_present = 1'b1;
          rec_nxt.payload_offset  = {9'd0, l4} + 16'(ihc_pkg::UDP_LEN);
          rec_nxt.payload_length  = pl_udp[15:0];
        end
      end
      ihc_pkg::PROTO_ICMP: begin
        rec_nxt.protocol_class  = ihc_pkg::CLS_ICMP;
        rec_nxt.service_code    = ihc_pkg::SVC_PING;
        rec_nxt.payload_present = 1'b1;
        rec_nxt.payload_offset  = {9'd0, l4};
        rec_nxt.payload_length  = plen[17] ? 16'd0 : plen[15:0];
      end
      default: begin
        rec_nxt.protocol_class = ihc_pkg::CLS_OTHER;
      end
    endcase

    if (hdr_valid && hdr_ready) begin
      rec_valid_nxt = 1'b1;
    end else if (rec_ready) begin
      rec_valid_nxt = 1'b0;
    end else begin
      rec_valid_nxt = rec_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
    end else begin
      rec_valid_r <= rec_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_valid && hdr_ready) begin
      rec_r <= rec_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ihc_checker.sv
// ----------------------------------------------------------------------------
// ihc_checker: port-level checks for the header classifier
// Watches the result channel and the consistency of record fields.
// ----------------------------------------------------------------------------
`default_nettype none

module ihc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_protocol_class,
  input wire logic [31:0] out_source_address,
  input wire logic [15:0] out_source_port,
  input wire logic [15:0] out_dest_port,
  input wire logic [3:0]  out_service_code,
  input wire logic        out_payload_present,
  input wire logic [15:0] out_payload_offset,
  input wire logic [15:0] out_payload_length
);

  // a stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_source_address)
      && $stable(out_payload_length))
    else $error("record changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("record valid right after reset");

  a_other_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_protocol_class == ihc_pkg::CLS_OTHER
      |-> out_service_code == ihc_pkg::SVC_NONE && !out_payload_present)
    else $error("non TCP/UDP/ICMP record carries service or payload");

  a_no_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_payload_present
      |-> out_payload_offset == 16'd0 && out_payload_length == 16'd0)
    else $error("payload fields set without payload");

  a_icmp_ping: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_protocol_class == ihc_pkg::CLS_ICMP
      |-> out_service_code == ihc_pkg::SVC_PING && out_source_port == 16'd0
        && out_dest_port == 16'd0)
    else $error("ICMP record with ports or wrong service");

endmodule

bind ipv4_l4_header_classifier_core ihc_checker u_ihc_checker (.*);

`default_nettype wire
